// ===== rtl/rdt_pkg.sv =====
// Shared types and constants of the retransmit drop timer.
// Depends on nothing; every other file of the block imports it.
package rdt_pkg;

   // In-flight window over packet ids, and the slot index width
   localparam int unsigned WINDOW   = 64;
   localparam int unsigned WIN_BITS = $clog2(WINDOW);

   localparam int unsigned ID_BITS  = 32;
   localparam int unsigned TO_BITS  = 24;
   localparam int unsigned BF_BITS  = 5;
   localparam int unsigned PROD_BITS = TO_BITS + BF_BITS;
   localparam int unsigned CSR_IDX_BITS = 3;

   // Register reset values
   localparam logic [TO_BITS-1:0] RST_INITIAL_TIMEOUT = 24'd1000;
   localparam logic [BF_BITS-1:0] RST_BACKOFF_FACTOR  = 5'd2;
   localparam logic [TO_BITS-1:0] RST_TIMEOUT_CEILING = 24'd60000;
   localparam logic               RST_OOO_ACK_RESTARTS = 1'b1;
   localparam logic               RST_DROP_ALL         = 1'b1;

   // Event codes
   typedef enum logic [2:0] {
      OP_GROUP_START = 3'd0,
      OP_SENT        = 3'd1,
      OP_ACK         = 3'd2,
      OP_REMOVED     = 3'd3,
      OP_ALL_REMOVED = 3'd4,
      OP_GROUP_END   = 3'd5,
      OP_TICK        = 3'd6,
      OP_SHUTDOWN    = 3'd7
   } op_type;

   // Register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_INITIAL_TIMEOUT = 3'd0,
      CSR_BACKOFF_FACTOR  = 3'd1,
      CSR_TIMEOUT_CEILING = 3'd2,
      CSR_OOO_ACK_RESTART = 3'd3,
      CSR_DROP_ALL        = 3'd4
   } csr_index_type;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_BACKOFF,
      S_DONE
   } state_type;

   // Status of the left-edge scan unit
   typedef struct packed {
      logic               done;
      logic               found;
      logic [ID_BITS-1:0] cand;
   } scan_status_type;

   // Status of the backoff unit
   typedef struct packed {
      logic               done;
      logic [TO_BITS-1:0] timeout;
   } backoff_status_type;

endpackage

// ===== rtl/rdt_req_if.sv =====
// Event channel of the retransmit drop timer: valid/ready plus event payload.
// Depends on rdt_pkg.
interface rdt_req_if import rdt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [2:0]         op;
   logic [ID_BITS-1:0] pkt_id;

   modport source (output valid, output op, output pkt_id, input ready);
   modport sink   (input valid, input op, input pkt_id, output ready);
endinterface

// ===== rtl/rdt_rsp_if.sv =====
// Result channel of the retransmit drop timer: valid/ready plus result payload.
// Depends on rdt_pkg.
interface rdt_rsp_if import rdt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               fired;
   logic               drop_all;
   logic               timer_armed;
   logic [TO_BITS-1:0] timeout_now;
   logic [ID_BITS-1:0] oldest_in_flight;
   logic               error;

   modport source (output valid, output fired, output drop_all, output timer_armed,
                   output timeout_now, output oldest_in_flight, output error,
                   input ready);
   modport sink   (input valid, input fired, input drop_all, input timer_armed,
                   input timeout_now, input oldest_in_flight, input error,
                   output ready);
endinterface

// ===== rtl/rdt_csr_if.sv =====
// Register write channel of the retransmit drop timer: valid/ready, index, data.
// Depends on rdt_pkg.
interface rdt_csr_if import rdt_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_BITS-1:0] index;
   logic [TO_BITS-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/rdt_scan.sv =====
// Left-edge scan unit: tests one candidate id of the in-flight bitmap per cycle.
// Depends on rdt_pkg.
module rdt_scan import rdt_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [ID_BITS-1:0]  base,
   input  logic [WIN_BITS-1:0] limit,
   input  logic [WINDOW-1:0]   map,
   output scan_status_type     status
);

   logic                active_ff, active_in;
   logic [WIN_BITS-1:0] k_ff, k_in;
   logic [WIN_BITS-1:0] limit_ff, limit_in;
   logic [ID_BITS-1:0]  base_ff, base_in;

   logic [ID_BITS-1:0]  cand;
   logic                hit;
   logic                last;

   // Candidate id and its bitmap slot
   always_comb begin
      cand = base_ff + ID_BITS'(k_ff);
      hit  = map[cand[WIN_BITS-1:0]];
      last = hit || (k_ff == limit_ff);
   end

   // Step the offset until a hit or the end of the span
   always_comb begin
      active_in = active_ff;
      k_in      = k_ff;
      limit_in  = limit_ff;
      base_in   = base_ff;
      if (start) begin
         active_in = 1'b1;
         k_in      = WIN_BITS'(1);
         limit_in  = limit;
         base_in   = base;
      end else if (active_ff) begin
         if (last) begin
            active_in = 1'b0;
         end else begin
            k_in = k_ff + WIN_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
      k_ff     <= k_in;
      limit_ff <= limit_in;
      base_ff  <= base_in;
   end

   assign status.done  = active_ff && last;
   assign status.found = hit;
   assign status.cand  = cand;

endmodule

// ===== rtl/rdt_backoff.sv =====
// Backoff unit: multiplies the timeout by a factor above one, then caps it at the ceiling.
// Depends on rdt_pkg.
module rdt_backoff import rdt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [TO_BITS-1:0] timeout,
   input  logic [BF_BITS-1:0] factor,
   input  logic [TO_BITS-1:0] ceiling,
   output backoff_status_type status
);

   logic                 pend_ff, pend_in;
   logic [PROD_BITS-1:0] prod_ff, prod_in;
   logic [TO_BITS-1:0]   keep_ff, keep_in;
   logic [TO_BITS-1:0]   ceil_ff, ceil_in;
   logic                 scale_ff, scale_in;

   logic [TO_BITS-1:0]   capped;
   logic [TO_BITS-1:0]   result;

   // Register the product and its operands
   always_comb begin
      pend_in  = start;
      prod_in  = prod_ff;
      keep_in  = keep_ff;
      ceil_in  = ceil_ff;
      scale_in = scale_ff;
      if (start) begin
         prod_in  = PROD_BITS'(timeout) * PROD_BITS'(factor);
         keep_in  = timeout;
         ceil_in  = (ceiling == '0) ? TO_BITS'(1) : ceiling;
         scale_in = (factor > BF_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
      prod_ff  <= prod_in;
      keep_ff  <= keep_in;
      ceil_ff  <= ceil_in;
      scale_ff <= scale_in;
   end

   // Cap, bypass for no backoff, and never leave a zero timeout
   always_comb begin
      capped = (prod_ff > PROD_BITS'(ceil_ff)) ? ceil_ff : prod_ff[TO_BITS-1:0];
      result = scale_ff ? capped : keep_ff;
      if (result == '0) begin
         result = TO_BITS'(1);
      end
   end

   assign status.done    = pend_ff;
   assign status.timeout = result;

endmodule

// ===== rtl/retransmit_drop_timer.sv =====
// Top level of the retransmit drop timer: sequencer, pipe state and timer.
// Depends on rdt_pkg, the channel interfaces, rdt_scan and rdt_backoff.
//
// Takes one event at a time and gives exactly one result per event. A plain
// event goes through accept, execute and load result, in that order. Removing
// the oldest in-flight packet runs the scan unit, which tests one later id of
// the bitmap per cycle up to the newest sent id; a tick that expires the timer
// runs the backoff multiply and cap. The next event is taken once the result
// sits in the output register; a held result stalls the block. Register writes
// are taken at any time and are meant to arrive while the block is idle.
module retransmit_drop_timer import rdt_pkg::*; (
   input logic       clock,
   input logic       reset,
   rdt_req_if.sink   req_ch,
   rdt_rsp_if.source rsp_ch,
   rdt_csr_if.sink   csr_ch
);

   state_type state_ff, state_in;

   // Latched event
   op_type             op_ff, op_in;
   logic [ID_BITS-1:0] id_ff, id_in;

   // Pipe and timer state
   logic [WINDOW-1:0]  map_ff, map_in;
   logic [ID_BITS-1:0] base_ff, base_in;
   logic [ID_BITS-1:0] newest_sent_ff, newest_sent_in;
   logic [ID_BITS-1:0] oldest_start_ff, oldest_start_in;
   logic [ID_BITS-1:0] newest_acked_ff, newest_acked_in;
   logic               in_group_ff, in_group_in;
   logic               running_ff, running_in;
   logic [TO_BITS-1:0] countdown_ff, countdown_in;
   logic [TO_BITS-1:0] cur_to_ff, cur_to_in;
   logic               shut_ff, shut_in;
   logic               fired_ff, fired_in;
   logic               drop_ff, drop_in;
   logic               err_ff, err_in;

   // Registers
   logic [TO_BITS-1:0] cfg_init_ff, cfg_init_in;
   logic [BF_BITS-1:0] cfg_factor_ff, cfg_factor_in;
   logic [TO_BITS-1:0] cfg_ceil_ff, cfg_ceil_in;
   logic               cfg_ooo_ff, cfg_ooo_in;
   logic               cfg_drop_ff, cfg_drop_in;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_fired_ff, rsp_fired_in;
   logic               rsp_drop_ff, rsp_drop_in;
   logic               rsp_run_ff, rsp_run_in;
   logic [TO_BITS-1:0] rsp_to_ff, rsp_to_in;
   logic [ID_BITS-1:0] rsp_oldest_ff, rsp_oldest_in;
   logic               rsp_err_ff, rsp_err_in;

   logic               req_fire;
   logic               rsp_load;
   logic               scan_go;
   logic               backoff_go;
   logic               nonempty;
   logic               in_flight;
   logic [ID_BITS-1:0] oldest_now;
   logic [ID_BITS-1:0] diff;
   logic [ID_BITS-1:0] span;
   logic [WIN_BITS-1:0] scan_limit;
   logic [TO_BITS-1:0] arm_value;
   logic [TO_BITS-1:0] cd_dec;

   scan_status_type    scan_st;
   backoff_status_type bo_st;

   // Scan and backoff units
   rdt_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .start  (scan_go),
      .base   (base_ff),
      .limit  (scan_limit),
      .map    (map_ff),
      .status (scan_st)
   );

   rdt_backoff u_backoff (
      .clock   (clock),
      .reset   (reset),
      .start   (backoff_go),
      .timeout (cur_to_ff),
      .factor  (cfg_factor_ff),
      .ceiling (cfg_ceil_ff),
      .status  (bo_st)
   );

   // Handshake outputs
   always_comb begin
      req_ch.ready = (state_ff == S_IDLE);
      csr_ch.ready = 1'b1;
      req_fire     = req_ch.valid && req_ch.ready;
      rsp_load     = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ch.ready);
   end

   // Pipe views used by the event logic
   always_comb begin
      nonempty   = map_ff[base_ff[WIN_BITS-1:0]];
      oldest_now = nonempty ? base_ff : '0;
      diff       = id_ff - base_ff;
      in_flight  = nonempty && (id_ff >= base_ff) && (diff < ID_BITS'(WINDOW)) &&
                   map_ff[id_ff[WIN_BITS-1:0]];
      span       = newest_sent_ff - base_ff;
      scan_limit = (span >= ID_BITS'(WINDOW - 1)) ? WIN_BITS'(WINDOW - 1)
                                                  : span[WIN_BITS-1:0];
      arm_value  = (cur_to_ff == '0) ? TO_BITS'(1) : cur_to_ff;
      cd_dec     = (countdown_ff == '0) ? '0 : countdown_ff - TO_BITS'(1);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (scan_go) begin
               state_in = S_SCAN;
            end else if (backoff_go) begin
               state_in = S_BACKOFF;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SCAN: begin
            if (scan_st.done) begin
               state_in = S_DONE;
            end
         end
         S_BACKOFF: begin
            if (bo_st.done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Event execution and register writes
   always_comb begin
      op_in           = op_ff;
      id_in           = id_ff;
      map_in          = map_ff;
      base_in         = base_ff;
      newest_sent_in  = newest_sent_ff;
      oldest_start_in = oldest_start_ff;
      newest_acked_in = newest_acked_ff;
      in_group_in     = in_group_ff;
      running_in      = running_ff;
      countdown_in    = countdown_ff;
      cur_to_in       = cur_to_ff;
      shut_in         = shut_ff;
      fired_in        = fired_ff;
      drop_in         = drop_ff;
      err_in          = err_ff;
      cfg_init_in     = cfg_init_ff;
      cfg_factor_in   = cfg_factor_ff;
      cfg_ceil_in     = cfg_ceil_ff;
      cfg_ooo_in      = cfg_ooo_ff;
      cfg_drop_in     = cfg_drop_ff;
      scan_go         = 1'b0;
      backoff_go      = 1'b0;

      // Latch the event and clear the per-event flags
      if (req_fire) begin
         op_in    = op_type'(req_ch.op);
         id_in    = req_ch.pkt_id;
         fired_in = 1'b0;
         drop_in  = 1'b0;
         err_in   = 1'b0;
      end

      if (state_ff == S_EXEC) begin
         case (op_ff)
            OP_GROUP_START: begin
               if (in_group_ff) begin
                  err_in = 1'b1;
               end else begin
                  in_group_in     = 1'b1;
                  oldest_start_in = oldest_now;
                  newest_acked_in = '0;
               end
            end
            OP_SENT: begin
               if (!in_group_ff || (id_ff == '0) || (id_ff <= newest_sent_ff)) begin
                  err_in = 1'b1;
               end else if (!nonempty) begin
                  base_in                         = id_ff;
                  map_in[id_ff[WIN_BITS-1:0]]     = 1'b1;
                  newest_sent_in                  = id_ff;
               end else if (diff >= ID_BITS'(WINDOW)) begin
                  err_in = 1'b1;
               end else begin
                  map_in[id_ff[WIN_BITS-1:0]] = 1'b1;
                  newest_sent_in              = id_ff;
               end
            end
            OP_ACK: begin
               if (!in_group_ff || !in_flight) begin
                  err_in = 1'b1;
               end else if (id_ff > newest_acked_ff) begin
                  newest_acked_in = id_ff;
               end
            end
            OP_REMOVED: begin
               if (!in_group_ff || !in_flight) begin
                  err_in = 1'b1;
               end else begin
                  map_in[id_ff[WIN_BITS-1:0]] = 1'b0;
                  // Oldest removed: search forward for the new left edge
                  if ((id_ff == base_ff) && (scan_limit != '0)) begin
                     scan_go = 1'b1;
                  end
               end
            end
            OP_ALL_REMOVED: begin
               if (!in_group_ff) begin
                  err_in = 1'b1;
               end else begin
                  if (!nonempty) begin
                     err_in = 1'b1;
                  end
                  map_in = '0;
               end
            end
            OP_GROUP_END: begin
               if (!in_group_ff) begin
                  err_in = 1'b1;
               end else begin
                  in_group_in = 1'b0;
                  if (oldest_start_ff == '0) begin
                     if (oldest_now != '0 && !shut_ff) begin
                        running_in   = 1'b1;
                        countdown_in = arm_value;
                     end
                  end else if (oldest_now == '0) begin
                     running_in = 1'b0;
                  end else if ((oldest_now != oldest_start_ff) ||
                               ((newest_acked_ff != '0) && cfg_ooo_ff)) begin
                     if (!shut_ff) begin
                        running_in   = 1'b1;
                        countdown_in = arm_value;
                     end
                  end
               end
            end
            OP_TICK: begin
               if (!shut_ff && running_ff) begin
                  countdown_in = cd_dec;
                  if (cd_dec == '0) begin
                     running_in = 1'b0;
                     fired_in   = 1'b1;
                     drop_in    = cfg_drop_ff;
                     backoff_go = 1'b1;
                  end
               end
            end
            OP_SHUTDOWN: begin
               running_in   = 1'b0;
               countdown_in = '0;
               shut_in      = 1'b1;
            end
            default: ;
         endcase
      end

      // Move the left edge to the scan hit
      if ((state_ff == S_SCAN) && scan_st.done && scan_st.found) begin
         base_in = scan_st.cand;
      end

      // Take the backed-off timeout
      if ((state_ff == S_BACKOFF) && bo_st.done) begin
         cur_to_in = bo_st.timeout;
      end

      // Register writes
      if (csr_ch.valid && csr_ch.ready) begin
         case (csr_index_type'(csr_ch.index))
            CSR_INITIAL_TIMEOUT: begin
               cfg_init_in = csr_ch.data;
               cur_to_in   = csr_ch.data;
            end
            CSR_BACKOFF_FACTOR:  cfg_factor_in = csr_ch.data[BF_BITS-1:0];
            CSR_TIMEOUT_CEILING: cfg_ceil_in   = csr_ch.data;
            CSR_OOO_ACK_RESTART: cfg_ooo_in    = csr_ch.data[0];
            CSR_DROP_ALL:        cfg_drop_in   = csr_ch.data[0];
            default: ;
         endcase
      end
   end

   // Result register: load at the end of the event, drop on transfer
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_fired_in  = rsp_fired_ff;
      rsp_drop_in   = rsp_drop_ff;
      rsp_run_in    = rsp_run_ff;
      rsp_to_in     = rsp_to_ff;
      rsp_oldest_in = rsp_oldest_ff;
      rsp_err_in    = rsp_err_ff;
      if (rsp_ch.valid && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_fired_in  = fired_ff;
         rsp_drop_in   = drop_ff;
         rsp_run_in    = running_ff;
         rsp_to_in     = cur_to_ff;
         rsp_oldest_in = oldest_now;
         rsp_err_in    = err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         map_ff          <= '0;
         base_ff         <= '0;
         newest_sent_ff  <= '0;
         oldest_start_ff <= '0;
         newest_acked_ff <= '0;
         in_group_ff     <= 1'b0;
         running_ff      <= 1'b0;
         countdown_ff    <= '0;
         cur_to_ff       <= RST_INITIAL_TIMEOUT;
         shut_ff         <= 1'b0;
         cfg_init_ff     <= RST_INITIAL_TIMEOUT;
         cfg_factor_ff   <= RST_BACKOFF_FACTOR;
         cfg_ceil_ff     <= RST_TIMEOUT_CEILING;
         cfg_ooo_ff      <= RST_OOO_ACK_RESTARTS;
         cfg_drop_ff     <= RST_DROP_ALL;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         map_ff          <= map_in;
         base_ff         <= base_in;
         newest_sent_ff  <= newest_sent_in;
         oldest_start_ff <= oldest_start_in;
         newest_acked_ff <= newest_acked_in;
         in_group_ff     <= in_group_in;
         running_ff      <= running_in;
         countdown_ff    <= countdown_in;
         cur_to_ff       <= cur_to_in;
         shut_ff         <= shut_in;
         cfg_init_ff     <= cfg_init_in;
         cfg_factor_ff   <= cfg_factor_in;
         cfg_ceil_ff     <= cfg_ceil_in;
         cfg_ooo_ff      <= cfg_ooo_in;
         cfg_drop_ff     <= cfg_drop_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      op_ff         <= op_in;
      id_ff         <= id_in;
      fired_ff      <= fired_in;
      drop_ff       <= drop_in;
      err_ff        <= err_in;
      rsp_fired_ff  <= rsp_fired_in;
      rsp_drop_ff   <= rsp_drop_in;
      rsp_run_ff    <= rsp_run_in;
      rsp_to_ff     <= rsp_to_in;
      rsp_oldest_ff <= rsp_oldest_in;
      rsp_err_ff    <= rsp_err_in;
   end

   // Drive the result channel
   always_comb begin
      rsp_ch.valid            = rsp_valid_ff;
      rsp_ch.fired            = rsp_fired_ff;
      rsp_ch.drop_all         = rsp_drop_ff;
      rsp_ch.timer_armed      = rsp_run_ff;
      rsp_ch.timeout_now      = rsp_to_ff;
      rsp_ch.oldest_in_flight = rsp_oldest_ff;
      rsp_ch.error            = rsp_err_ff;
   end

endmodule

// ===== rtl/rdt_checker.sv =====
// Port-level checks of the retransmit drop timer, bound to the top level.
// Depends on rdt_pkg and retransmit_drop_timer.
module rdt_checker import rdt_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               fired,
   input logic               drop_all,
   input logic               timer_armed,
   input logic [TO_BITS-1:0] timeout_now
);

   // Hold a pending result until transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   // One event at a time: no new transfer right after one
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("event taken while previous one in work");

   // Expiry disarms the timer
   a_fired_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && fired |-> !timer_armed)
      else $error("timer still running after firing");

   // Drop-all only with a firing, and backoff never leaves a zero timeout
   a_drop_with_fire: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (drop_all || fired) |-> fired && (timeout_now != '0))
      else $error("drop_all without firing or zero timeout after expiry");

endmodule

bind retransmit_drop_timer rdt_checker u_rdt_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .fired       (rsp_ch.fired),
   .drop_all    (rsp_ch.drop_all),
   .timer_armed (rsp_ch.timer_armed),
   .timeout_now (rsp_ch.timeout_now)
);
